// File: src/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg: shared types, codes and helpers for the Playfair block
// Letter and cell codes, action codes, sequencer states, the structs between
// the sequencer and the key store, and small cell arithmetic.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int SIDE    = 5;
   localparam int CELLS   = SIDE * SIDE;
   localparam int LETTERS = 26;
   localparam int DATA_W  = 16;

   typedef logic [4:0]         letter_type;
   typedef logic [4:0]         cell_type;
   typedef logic [2:0]         coord_type;
   typedef logic [LETTERS-1:0] marks_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = letter_type'(LETTERS - 1);
   localparam marks_type  J_ONLY   = marks_type'(1) << LETTER_J;

   typedef enum logic [1:0] {
      ACT_KEY     = 2'd0,
      ACT_FILL    = 2'd1,
      ACT_ENCRYPT = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_FILL,
      ST_LOOK,
      ST_MAP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       sq_we;
      cell_type   sq_waddr;
      letter_type sq_wdata;
      logic       sq_re;
      cell_type   sq_raddr0;
      cell_type   sq_raddr1;
      logic       pl_we;
      letter_type pl_waddr;
      cell_type   pl_wdata;
      logic       pl_re;
      letter_type pl_raddr0;
      letter_type pl_raddr1;
   } mem_ctrl_type;

   typedef struct packed {
      letter_type sq_rd0;
      letter_type sq_rd1;
      cell_type   pl_rd0;
      cell_type   pl_rd1;
   } mem_rd_type;

   typedef struct packed {
      logic       valid;
      letter_type cipher_a;
      letter_type cipher_b;
      logic       status;
   } emit_type;

   // J folds into I; codes past Z saturate to Z
   function automatic letter_type fold_cipher(letter_type v);
      letter_type l;
      l = (v > LETTER_Z) ? LETTER_Z : v;
      if (l == LETTER_J) begin
         l = LETTER_I;
      end
      return l;
   endfunction

   function automatic letter_type fold_key(letter_type v);
      return (v == LETTER_J) ? LETTER_I : v;
   endfunction

   function automatic coord_type cell_row(cell_type c);
      coord_type r;
      r = '0;
      for (int i = 1; i < SIDE; i++) begin
         if (c >= cell_type'(i * SIDE)) begin
            r = coord_type'(i);
         end
      end
      return r;
   endfunction

   function automatic coord_type cell_col(cell_type c);
      cell_type base;
      base = cell_type'(cell_row(c) * SIDE);
      return coord_type'(c - base);
   endfunction

   function automatic coord_type next_coord(coord_type x);
      return (x == coord_type'(SIDE - 1)) ? '0 : coord_type'(x + 3'd1);
   endfunction

   function automatic cell_type make_cell(coord_type r, coord_type c);
      return cell_type'(r * SIDE + c);
   endfunction

endpackage

// File: src/playfair_square_and_digram_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_square_and_digram_encrypt: Playfair key square and digram cipher
// Builds a 5x5 key square from key letters and encrypts letter pairs with it.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one command word; req_tuser selects key letter, end of key
//   or encrypt. Every word returns exactly one rsp_ word.
//   The block takes one word at a time: req_tready is high only while the
//   sequencer is idle. A key letter goes through the key and emit steps, an
//   encrypt through look, map and emit (two place reads, then two square
//   reads, each a registered memory access), a refused encrypt or unknown
//   action straight to emit, end of key through the fill walk (all 26
//   letters, one per cycle through the shared placement unit) and emit.
//   The result sits in an output register; while the receiver stalls the
//   next word is still accepted and worked on, and holds in its final step
//   until the output register frees up.
//   Reset empties the key: only J marked used, nothing placed, square not
//   complete. Square and place memories need no clearing, since they are
//   only read once the square is complete and every entry has been written.
// ----------------------------------------------------------------------------
module playfair_square_and_digram_encrypt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pfe_pkg::DATA_W-1:0] req_tdata,  // [4:0] letter_a, [9:5] letter_b
   input  logic [1:0]                 req_tuser,  // [1:0] action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pfe_pkg::DATA_W-1:0] rsp_tdata,  // [4:0] cipher_a, [9:5] cipher_b
   output logic [0:0]                 rsp_tuser   // [0] status
);
   import pfe_pkg::*;

   mem_ctrl_type mem_ctrl;
   mem_rd_type   mem_rd;
   emit_type     emit;
   logic         accept, out_free;

   logic       rsp_valid_ff;
   letter_type cipher_a_ff, cipher_b_ff;
   logic       status_ff;

   assign accept   = req_tvalid && req_tready;
   // the output register frees up when it is empty or drains this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   pfe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .action   (req_tuser),
      .letter_a (req_tdata[4:0]),
      .letter_b (req_tdata[9:5]),
      .out_free (out_free),
      .mem_rd   (mem_rd),
      .ready    (req_tready),
      .mem_ctrl (mem_ctrl),
      .emit     (emit)
   );

   pfe_store u_store (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .mem_rd   (mem_rd)
   );

   // output register: load a finished result, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         cipher_a_ff <= emit.cipher_a;
         cipher_b_ff <= emit.cipher_b;
         status_ff   <= emit.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W - 10){1'b0}}, cipher_b_ff, cipher_a_ff};
   assign rsp_tuser  = status_ff;

   // a refused encrypt never carries cipher letters
   a_refused_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("refused encrypt with nonzero cipher");

   // the sequencer goes busy after every accepted word
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("ready stayed high after accept");

   // handing a result to the output register returns the sequencer to idle
   a_idle_after_emit : assert property (@(posedge clock) disable iff (reset)
      emit.valid |=> (req_tready && rsp_tvalid))
      else $error("no idle or no valid after result load");

   // a result is only loaded while the output register can take it
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a waiting word");

endmodule

// File: src/pfe_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_store: key square and letter place memories
// One write port and two registered read ports per memory.
// ----------------------------------------------------------------------------
module pfe_store (
   input  logic                 clock,
   input  pfe_pkg::mem_ctrl_type mem_ctrl,
   output pfe_pkg::mem_rd_type  mem_rd
);
   import pfe_pkg::*;

   letter_type square_ff [CELLS];
   cell_type   place_ff  [LETTERS];
   letter_type sq_rd0_ff, sq_rd1_ff;
   cell_type   pl_rd0_ff, pl_rd1_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.sq_we) begin
         square_ff[mem_ctrl.sq_waddr] <= mem_ctrl.sq_wdata;
      end
      if (mem_ctrl.sq_re) begin
         sq_rd0_ff <= square_ff[mem_ctrl.sq_raddr0];
         sq_rd1_ff <= square_ff[mem_ctrl.sq_raddr1];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.pl_we) begin
         place_ff[mem_ctrl.pl_waddr] <= mem_ctrl.pl_wdata;
      end
      if (mem_ctrl.pl_re) begin
         pl_rd0_ff <= place_ff[mem_ctrl.pl_raddr0];
         pl_rd1_ff <= place_ff[mem_ctrl.pl_raddr1];
      end
   end

   assign mem_rd.sq_rd0 = sq_rd0_ff;
   assign mem_rd.sq_rd1 = sq_rd1_ff;
   assign mem_rd.pl_rd0 = pl_rd0_ff;
   assign mem_rd.pl_rd1 = pl_rd1_ff;

endmodule

// File: src/pfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl: sequencer and shared letter placement unit
// Steps key letters, the end-of-key walk and digram lookups one at a time.
// ----------------------------------------------------------------------------
module pfe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            action,
   input  pfe_pkg::letter_type   letter_a,
   input  pfe_pkg::letter_type   letter_b,
   input  logic                  out_free,
   input  pfe_pkg::mem_rd_type   mem_rd,
   output logic                  ready,
   output pfe_pkg::mem_ctrl_type mem_ctrl,
   output pfe_pkg::emit_type     emit
);
   import pfe_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] action_ff;
   letter_type letter_a_ff, letter_b_ff;
   marks_type  used_ff, used_in;
   cell_type   fill_ff, fill_in;
   logic       complete_ff, complete_in;
   letter_type walk_ff, walk_in;

   // shared placement unit
   marks_type  marks_base;
   cell_type   fill_base;
   letter_type place_letter;
   logic       place_en, letter_free, place_do;

   // digram mapping
   coord_type  r1, c1, r2, c2;
   cell_type   t1, t2;
   logic       is_encrypt, walk_last;

   assign is_encrypt = (action_ff == ACT_ENCRYPT);
   assign walk_last  = (walk_ff == LETTER_Z);

   always_comb begin
      marks_base = used_ff;
      fill_base  = fill_ff;
      if (state_ff == ST_KEY && complete_ff) begin
         marks_base = J_ONLY;
         fill_base  = '0;
      end
      place_letter = (state_ff == ST_FILL) ? walk_ff : fold_key(letter_a_ff);
      place_en     = (state_ff == ST_KEY) || (state_ff == ST_FILL);
      letter_free  = (place_letter <= LETTER_Z) ? !marks_base[place_letter] : 1'b0;
      place_do     = place_en && letter_free && (fill_base < cell_type'(CELLS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_KEY:     state_in = ST_KEY;
                  ACT_FILL:    state_in = ST_FILL;
                  ACT_ENCRYPT: state_in = complete_ff ? ST_LOOK : ST_EMIT;
                  default:     state_in = ST_EMIT;
               endcase
            end
         end
         ST_KEY:  state_in = ST_EMIT;
         ST_FILL: state_in = walk_last ? ST_EMIT : ST_FILL;
         ST_LOOK: state_in = ST_MAP;
         ST_MAP:  state_in = ST_EMIT;
         ST_EMIT: state_in = out_free ? ST_IDLE : ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // key state update
   always_comb begin
      used_in     = used_ff;
      fill_in     = fill_ff;
      complete_in = complete_ff;
      walk_in     = '0;
      if (place_en) begin
         used_in = marks_base | (place_do ? (marks_type'(1) << place_letter) : '0);
         fill_in = fill_base + cell_type'(place_do);
      end
      if (state_ff == ST_KEY) begin
         complete_in = 1'b0;
      end
      if (state_ff == ST_FILL) begin
         walk_in = walk_ff + letter_type'(1);
         if (walk_last) begin
            complete_in = 1'b1;
         end
      end
   end

   always_comb begin
      r1 = cell_row(mem_rd.pl_rd0);
      c1 = cell_col(mem_rd.pl_rd0);
      r2 = cell_row(mem_rd.pl_rd1);
      c2 = cell_col(mem_rd.pl_rd1);
      if (r1 == r2) begin
         t1 = make_cell(r1, next_coord(c1));
         t2 = make_cell(r2, next_coord(c2));
      end else if (c1 == c2) begin
         t1 = make_cell(next_coord(r1), c1);
         t2 = make_cell(next_coord(r2), c2);
      end else begin
         t1 = make_cell(r1, c2);
         t2 = make_cell(r2, c1);
      end
   end

   // outputs
   always_comb begin
      ready              = (state_ff == ST_IDLE);
      mem_ctrl.sq_we     = place_do;
      mem_ctrl.sq_waddr  = fill_base;
      mem_ctrl.sq_wdata  = place_letter;
      mem_ctrl.pl_we     = place_do;
      mem_ctrl.pl_waddr  = place_letter;
      mem_ctrl.pl_wdata  = fill_base;
      mem_ctrl.pl_re     = (state_ff == ST_LOOK);
      mem_ctrl.pl_raddr0 = fold_cipher(letter_a_ff);
      mem_ctrl.pl_raddr1 = fold_cipher(letter_b_ff);
      mem_ctrl.sq_re     = (state_ff == ST_MAP);
      mem_ctrl.sq_raddr0 = t1;
      mem_ctrl.sq_raddr1 = t2;
      emit.valid         = (state_ff == ST_EMIT) && out_free;
      emit.status        = is_encrypt && !complete_ff;
      emit.cipher_a      = (is_encrypt && complete_ff) ? mem_rd.sq_rd0 : '0;
      emit.cipher_b      = (is_encrypt && complete_ff) ? mem_rd.sq_rd1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         used_ff     <= J_ONLY;
         fill_ff     <= '0;
         complete_ff <= 1'b0;
         walk_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         fill_ff     <= fill_in;
         complete_ff <= complete_in;
         walk_ff     <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= action;
         letter_a_ff <= letter_a;
         letter_b_ff <= letter_b;
      end
   end

endmodule

// File: tb/playfair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_checker: scoreboard for the Playfair square and digram cipher
// Watches both stream channels, keeps its own key square, predicts one
// response word per accepted request word and compares field by field.
// ----------------------------------------------------------------------------
module playfair_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [pfe_pkg::DATA_W-1:0] req_tdata,
   input  logic [1:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [pfe_pkg::DATA_W-1:0] rsp_tdata,
   input  logic [0:0]                 rsp_tuser,
   output int unsigned                fail_count,
   output int unsigned                words_in_flight
);
   import pfe_pkg::*;

   typedef struct packed {
      letter_type cipher_a;
      letter_type cipher_b;
      logic       status;
   } cipher_word_type;

   letter_type      key_square [CELLS];
   cell_type        letter_cell [LETTERS];
   marks_type       placed_marks;
   int unsigned     cells_filled;
   logic            square_done;
   int unsigned     failures;
   cipher_word_type expected_ciphers [$];

   function automatic void clear_key();
      placed_marks = J_ONLY;
      cells_filled = 0;
      square_done  = 1'b0;
   endfunction

   function automatic void place_key_letter(int unsigned l);
      if (l < LETTERS && cells_filled < CELLS && !placed_marks[l]) begin
         key_square[cells_filled] = letter_type'(l);
         letter_cell[l]           = cell_type'(cells_filled);
         placed_marks[l]          = 1'b1;
         cells_filled++;
      end
   endfunction

   // saturate past Z, then fold J into I
   function automatic int unsigned digram_letter(letter_type v);
      int unsigned l;
      l = (v >= LETTERS) ? LETTERS - 1 : v;
      if (l == LETTER_J) begin
         l = LETTER_I;
      end
      return l;
   endfunction

   function automatic cipher_word_type encipher_word(logic [1:0] act, letter_type a,
                                                     letter_type b);
      cipher_word_type w;
      int unsigned     pa, pb, ra, rb, ka, kb;
      w = '0;
      case (act)
         ACT_KEY: begin
            if (square_done) begin
               clear_key();
            end
            if (a < LETTERS) begin
               place_key_letter((a == LETTER_J) ? LETTER_I : a);
            end
         end
         ACT_FILL: begin
            for (int l = 0; l < LETTERS; l++) begin
               place_key_letter(l);
            end
            square_done = 1'b1;
         end
         ACT_ENCRYPT: begin
            if (!square_done) begin
               w.status = 1'b1;
            end else begin
               pa = letter_cell[digram_letter(a)] % CELLS;
               pb = letter_cell[digram_letter(b)] % CELLS;
               ra = pa / SIDE;
               ka = pa % SIDE;
               rb = pb / SIDE;
               kb = pb % SIDE;
               if (ra == rb) begin
                  w.cipher_a = key_square[ra * SIDE + (ka + 1) % SIDE];
                  w.cipher_b = key_square[rb * SIDE + (kb + 1) % SIDE];
               end else if (ka == kb) begin
                  w.cipher_a = key_square[((ra + 1) % SIDE) * SIDE + ka];
                  w.cipher_b = key_square[((rb + 1) % SIDE) * SIDE + kb];
               end else begin
                  w.cipher_a = key_square[ra * SIDE + kb];
                  w.cipher_b = key_square[rb * SIDE + ka];
               end
            end
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      cipher_word_type got, want;
      if (reset) begin
         clear_key();
         expected_ciphers.delete();
         failures = 0;
         fail_count      <= 0;
         words_in_flight <= 0;
      end else begin
         // the response to a word never leaves in the cycle it is accepted
         if (rsp_tvalid && rsp_tready) begin
            got.cipher_a = rsp_tdata[4:0];
            got.cipher_b = rsp_tdata[9:5];
            got.status   = rsp_tuser[0];
            if (expected_ciphers.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: unexpected response a=%0d b=%0d status=%0d", $realtime,
                           got.cipher_a, got.cipher_b, got.status);
               end
            end else begin
               want = expected_ciphers.pop_front();
               if (got.cipher_a !== want.cipher_a || got.cipher_b !== want.cipher_b ||
                   got.status !== want.status) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: expected a=%0d b=%0d s=%0d, got a=%0d b=%0d s=%0d",
                              $realtime, want.cipher_a, want.cipher_b, want.status,
                              got.cipher_a, got.cipher_b, got.status);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_ciphers.push_back(encipher_word(req_tuser, req_tdata[4:0],
                                                     req_tdata[9:5]));
         end
         fail_count      <= failures;
         words_in_flight <= expected_ciphers.size();
      end
   end

endmodule

// File: tb/tb_playfair_square_and_digram_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_square_and_digram_encrypt: regression for the Playfair block
// Drives key letters, end-of-key and digram words in random bursts against a
// stalling receiver; the checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module tb_playfair_square_and_digram_encrypt;
   import pfe_pkg::*;

   // action code the block does not define; it must answer with all zeros
   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam letter_type LETTER_TOP   = 5'd31;
   localparam int         RESET_CYCLES = 11;
   localparam int         RANDOM_WORDS = 1100;
   // margin for an end-of-key walk over all 26 letters plus the return to idle
   localparam int         DRAIN_CYCLES = 40;
   localparam int         CYCLE_LIMIT  = 300000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_QUARTER,
      READY_SPARSE
   } ready_mode_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;   // [4:0] letter_a, [9:5] letter_b
   logic [1:0]          req_tuser  = '0;   // [1:0] action
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;         // [4:0] cipher_a, [9:5] cipher_b
   logic [0:0]          rsp_tuser;         // [0] status

   int unsigned         fail_count;
   int unsigned         words_in_flight;
   int unsigned         words_sent  = 0;
   int unsigned         burst_left  = 1;
   int unsigned         cycle_count = 0;

   ready_mode_type      ready_mode  = READY_ALWAYS;
   int unsigned         mode_left   = 0;
   logic [7:0]          ready_phase = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   playfair_square_and_digram_encrypt uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   playfair_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .words_in_flight (words_in_flight)
   );

   // Receiver: switch at random between four stall patterns so that
   // back-pressure lands on key, fill and encrypt words alike.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         ready_phase <= ready_phase + 8'd1;
         case (ready_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_RANDOM:  rsp_tready <= 1'($urandom_range(0, 1));
            READY_QUARTER: rsp_tready <= (ready_phase[1:0] == 2'd0);
            default:       rsp_tready <= (ready_phase[3:0] == 4'd0);
         endcase
      end
   end

   // letter code from an ASCII capital
   function automatic letter_type ltr(byte c);
      return letter_type'(c - "A");
   endfunction

   // mostly legal letters, with J and out-of-range codes mixed in
   function automatic letter_type pick_letter();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         return letter_type'($urandom_range(26, 31));
      end
      if (roll == 1) begin
         return LETTER_J;
      end
      return letter_type'($urandom_range(0, 25));
   endfunction

   function automatic letter_type any_letter();
      return letter_type'($urandom_range(0, 31));
   endfunction

   // Present one word and hold it until accepted; at the end of a burst,
   // pick the next burst length and mostly drop valid for a random gap.
   task automatic send_word(input logic [1:0] act, input letter_type a, input letter_type b);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'd0, b, a};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      words_sent++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Watchdog: any hang, lost response or leftover expectation ends here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("playfair_square_and_digram_encrypt regression: fail");
      $finish;
   end

   initial begin
      int unsigned key_len, run_len, random_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: refused encrypt from reset, unused action, empty key
      send_word(ACT_ENCRYPT, ltr("A"), ltr("B"));
      send_word(ACT_UNUSED, LETTER_TOP, LETTER_TOP);
      send_word(ACT_FILL, '0, '0);
      // alphabetical square: row, row wrap, column, column wrap, rectangle
      send_word(ACT_ENCRYPT, ltr("A"), ltr("B"));
      send_word(ACT_ENCRYPT, ltr("E"), ltr("A"));
      send_word(ACT_ENCRYPT, ltr("A"), ltr("F"));
      send_word(ACT_ENCRYPT, ltr("V"), ltr("A"));
      send_word(ACT_ENCRYPT, ltr("A"), ltr("G"));
      // J folds into I; codes past Z saturate; a doubled letter
      send_word(ACT_ENCRYPT, LETTER_J, ltr("K"));
      send_word(ACT_ENCRYPT, LETTER_TOP, 5'd26);
      send_word(ACT_ENCRYPT, ltr("A"), ltr("A"));
      // end of key on a complete square leaves it complete
      send_word(ACT_FILL, LETTER_TOP, LETTER_TOP);
      // new key clears the old square; J and I collide, repeats and junk drop
      send_word(ACT_KEY, ltr("P"), '0);
      send_word(ACT_KEY, ltr("L"), LETTER_TOP);
      send_word(ACT_KEY, ltr("A"), '0);
      send_word(ACT_KEY, ltr("Y"), '0);
      send_word(ACT_KEY, ltr("F"), '0);
      send_word(ACT_KEY, LETTER_J, '0);
      send_word(ACT_KEY, ltr("I"), '0);
      send_word(ACT_KEY, LETTER_TOP, '0);
      send_word(ACT_KEY, ltr("A"), '0);
      send_word(ACT_FILL, '0, '0);
      send_word(ACT_ENCRYPT, ltr("H"), ltr("Z"));
      // out-of-range key letter still clears a complete square
      send_word(ACT_KEY, 5'd26, '0);
      send_word(ACT_ENCRYPT, ltr("H"), ltr("I"));

      // Random: mostly key phrases followed by fill and a run of digrams,
      // with raw noise words in between.
      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) < 8) begin
            key_len = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(0, 10);
            repeat (key_len) send_word(ACT_KEY, pick_letter(), any_letter());
            if ($urandom_range(0, 9) != 0) begin
               send_word(ACT_FILL, any_letter(), any_letter());
            end
            run_len = $urandom_range(8, 40);
            repeat (run_len) begin
               if ($urandom_range(0, 9) == 0) begin
                  key_len = pick_letter();
                  send_word(ACT_ENCRYPT, letter_type'(key_len), letter_type'(key_len));
               end else begin
                  send_word(ACT_ENCRYPT, pick_letter(), pick_letter());
               end
            end
         end else begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) begin
               send_word(2'($urandom_range(0, 3)), any_letter(), any_letter());
            end
         end
      end

      // drain: wait for every response, then let the block settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("playfair_square_and_digram_encrypt regression: pass");
      end else begin
         $display("playfair_square_and_digram_encrypt regression: fail");
      end
      $finish;
   end

endmodule
